// ===== hdl/xasd_pkg.sv =====
// Shared types and constants for the XOR archive stream deframer.
`default_nettype none

package xasd_pkg;

	// Parser phases, one-hot.
	typedef enum logic [9:0] {
		PH_MAGIC   = 10'b00_0000_0001,
		PH_VERSION = 10'b00_0000_0010,
		PH_FLAG    = 10'b00_0000_0100,
		PH_NAMELEN = 10'b00_0000_1000,
		PH_NAME    = 10'b00_0001_0000,
		PH_SIZE    = 10'b00_0010_0000,
		PH_TIME    = 10'b00_0100_0000,
		PH_BODY    = 10'b00_1000_0000,
		PH_TRAIL   = 10'b01_0000_0000,
		PH_DROP    = 10'b10_0000_0000
	} phase_t;

	// Section codes as seen on the output.
	localparam logic [3:0] SEC_MAGIC   = 4'd0;
	localparam logic [3:0] SEC_VERSION = 4'd1;
	localparam logic [3:0] SEC_FLAG    = 4'd2;
	localparam logic [3:0] SEC_NAMELEN = 4'd3;
	localparam logic [3:0] SEC_NAME    = 4'd4;
	localparam logic [3:0] SEC_SIZE    = 4'd5;
	localparam logic [3:0] SEC_TIME    = 4'd6;
	localparam logic [3:0] SEC_BODY    = 4'd7;
	localparam logic [3:0] SEC_TRAIL   = 4'd8;
	localparam logic [3:0] SEC_DROP    = 4'd9;

	localparam logic [1:0] FAULT_NONE    = 2'd0;
	localparam logic [1:0] FAULT_MAGIC   = 2'd1;
	localparam logic [1:0] FAULT_VERSION = 2'd2;
	localparam logic [1:0] FAULT_RECORDS = 2'd3;

	localparam logic [7:0] KEY_RESET = 8'hF7;
	localparam logic [7:0] FLAG_END  = 8'h80;
	localparam logic [7:0] VERSION_BYTE = 8'h00;

	// Register word indexes on the config port.
	localparam logic REG_KEY = 1'b0;

	typedef struct packed {
		logic [7:0]  plain_byte;
		logic [3:0]  section;
		logic [7:0]  record_number;
		logic        field_end;
		logic [31:0] size_value;
		logic [8:0]  records_seen;
		logic [1:0]  fault;
	} result_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] pos);
		logic [7:0] b;
		case (pos)
			2'd0: b = 8'hC0;
			2'd1: b = 8'h4A;
			2'd2: b = 8'hC0;
			default: b = 8'hBA;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/xasd_regs.sv =====
// APB configuration register holding the XOR key.
`default_nettype none

module xasd_regs
	import xasd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic [7:0]       xor_key
);

	logic [7:0] key_q;

	assign pready  = 1'b1;
	assign xor_key = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= KEY_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_KEY)) begin
			key_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_KEY) begin
			prdata = {24'd0, key_q};
		end
	end

endmodule

`default_nettype wire

// ===== hdl/xasd_table.sv =====
// Record table: body size and owner index per stored record, registered read.
`default_nettype none

module xasd_table #(
	parameter int DEPTH = 256,
	parameter int IW    = 8
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [IW-1:0] wr_addr,
	input  wire logic [31:0]   wr_size,
	input  wire logic [7:0]    wr_owner,
	input  wire logic [IW-1:0] rd_addr,
	output logic [31:0]        rd_size,
	output logic [7:0]         rd_owner
);

	logic [31:0] size_mem  [DEPTH];
	logic [7:0]  owner_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			size_mem[wr_addr]  <= wr_size;
			owner_mem[wr_addr] <= wr_owner;
		end
	end

	always_ff @(posedge clk) begin
		rd_size  <= size_mem[rd_addr];
		rd_owner <= owner_mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== hdl/xasd_parser.sv =====
// Archive parser: phase tracking, header decode, record table and body tagging.
`default_nettype none

module xasd_parser
	import xasd_pkg::*;
#(
	parameter int MAX_RECORDS = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] plain,
	output result_t         result
);

	localparam int CW = $clog2(MAX_RECORDS + 1);
	localparam int IW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_RECORDS);

	phase_t        phase_q, phase_d;
	logic [2:0]    pos_q, pos_d;
	logic [7:0]    name_left_q, name_left_d;
	logic [31:0]   acc_q, acc_d;
	logic          mism_q, mism_d;
	logic [CW-1:0] rec_cnt_q, rec_cnt_d;
	logic [CW-1:0] fill_q, fill_d;
	logic [CW-1:0] rd_idx_q, rd_idx_d;
	logic [31:0]   body_left_q, body_left_d;
	logic          body_start_q, body_start_d;
	logic [1:0]    fault_q, fault_d;

	logic          wr_en;
	logic [31:0]   rd_size;
	logic [7:0]    rd_owner;
	logic [31:0]   left_eff;
	logic [31:0]   left_dec;
	logic [CW-1:0] rd_next;
	logic          mism_now;

	xasd_table #(
		.DEPTH(MAX_RECORDS),
		.IW   (IW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (fill_q[IW-1:0]),
		.wr_size (acc_q),
		.wr_owner(rec_cnt_q[7:0]),
		.rd_addr (rd_idx_d[IW-1:0]),
		.rd_size (rd_size),
		.rd_owner(rd_owner)
	);

	// rd_size/rd_owner always reflect the entry at rd_idx_q: the address
	// follows the next index, so data is ready when the body starts.
	assign left_eff = body_start_q ? rd_size : body_left_q;
	assign left_dec = (left_eff != 32'd0) ? left_eff - 32'd1 : 32'd0;
	assign rd_next  = rd_idx_q + CW'(1);

	always_comb begin
		phase_d      = phase_q;
		pos_d        = pos_q;
		name_left_d  = name_left_q;
		acc_d        = acc_q;
		mism_d       = mism_q;
		rec_cnt_d    = rec_cnt_q;
		fill_d       = fill_q;
		rd_idx_d     = rd_idx_q;
		body_left_d  = body_left_q;
		body_start_d = body_start_q;
		fault_d      = fault_q;
		wr_en        = 1'b0;
		mism_now     = 1'b0;

		result.plain_byte    = plain;
		result.section       = SEC_DROP;
		result.record_number = 8'd0;
		result.field_end     = 1'b0;
		result.size_value    = 32'd0;

		if (step) begin
			unique case (phase_q)
				PH_MAGIC, PH_VERSION: begin
					result.section = (phase_q == PH_MAGIC) ? SEC_MAGIC : SEC_VERSION;
					mism_now = (phase_q == PH_MAGIC) ?
						(plain != magic_byte(pos_q[1:0])) : (plain != VERSION_BYTE);
					if (pos_q[1:0] == 2'd3) begin
						result.field_end = 1'b1;
						pos_d  = 3'd0;
						mism_d = 1'b0;
						if (mism_q || mism_now) begin
							fault_d = (phase_q == PH_MAGIC) ? FAULT_MAGIC : FAULT_VERSION;
							phase_d = PH_DROP;
						end else begin
							phase_d = (phase_q == PH_MAGIC) ? PH_VERSION : PH_FLAG;
						end
					end else begin
						pos_d  = {1'b0, pos_q[1:0] + 2'd1};
						mism_d = mism_q | mism_now;
					end
				end
				PH_FLAG: begin
					result.section       = SEC_FLAG;
					result.record_number = rec_cnt_q[7:0];
					result.field_end     = 1'b1;
					if (plain == FLAG_END) begin
						rd_idx_d = '0;
						if (fill_q != '0) begin
							phase_d      = PH_BODY;
							body_start_d = 1'b1;
						end else begin
							phase_d     = PH_TRAIL;
							body_left_d = 32'd0;
						end
					end else if (rec_cnt_q >= MAX_C) begin
						fault_d = FAULT_RECORDS;
						phase_d = PH_DROP;
					end else begin
						phase_d = PH_NAMELEN;
					end
				end
				PH_NAMELEN: begin
					result.section       = SEC_NAMELEN;
					result.record_number = rec_cnt_q[7:0];
					result.field_end     = 1'b1;
					pos_d = 3'd0;
					acc_d = 32'd0;
					if (plain == 8'd0) begin
						phase_d = PH_SIZE;
					end else begin
						name_left_d = plain;
						phase_d     = PH_NAME;
					end
				end
				PH_NAME: begin
					result.section       = SEC_NAME;
					result.record_number = rec_cnt_q[7:0];
					if (name_left_q <= 8'd1) begin
						name_left_d      = 8'd0;
						result.field_end = 1'b1;
						pos_d   = 3'd0;
						acc_d   = 32'd0;
						phase_d = PH_SIZE;
					end else begin
						name_left_d = name_left_q - 8'd1;
					end
				end
				PH_SIZE: begin
					result.section       = SEC_SIZE;
					result.record_number = rec_cnt_q[7:0];
					case (pos_q[1:0])
						2'd0: acc_d = acc_q | {24'd0, plain};
						2'd1: acc_d = acc_q | {16'd0, plain, 8'd0};
						2'd2: acc_d = acc_q | {8'd0, plain, 16'd0};
						default: acc_d = acc_q | {plain, 24'd0};
					endcase
					result.size_value = acc_d;
					if (pos_q[1:0] == 2'd3) begin
						result.field_end = 1'b1;
						pos_d   = 3'd0;
						phase_d = PH_TIME;
					end else begin
						pos_d = {1'b0, pos_q[1:0] + 2'd1};
					end
				end
				PH_TIME: begin
					result.section       = SEC_TIME;
					result.record_number = rec_cnt_q[7:0];
					if (pos_q == 3'd7) begin
						result.field_end = 1'b1;
						pos_d = 3'd0;
						if (acc_q != 32'd0 && fill_q < MAX_C) begin
							wr_en  = 1'b1;
							fill_d = fill_q + CW'(1);
						end
						rec_cnt_d = rec_cnt_q + CW'(1);
						phase_d   = PH_FLAG;
					end else begin
						pos_d = pos_q + 3'd1;
					end
				end
				PH_BODY: begin
					result.section       = SEC_BODY;
					result.record_number = rd_owner;
					body_start_d = 1'b0;
					body_left_d  = left_dec;
					if (left_dec == 32'd0) begin
						result.field_end = 1'b1;
						rd_idx_d = rd_next;
						if (rd_next < fill_q) begin
							phase_d      = PH_BODY;
							body_start_d = 1'b1;
						end else begin
							phase_d = PH_TRAIL;
						end
					end
				end
				PH_TRAIL: begin
					result.section = SEC_TRAIL;
				end
				default: begin
					result.section = SEC_DROP;
					phase_d        = PH_DROP;
				end
			endcase
		end

		result.records_seen = 9'(rec_cnt_d);
		result.fault        = fault_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_MAGIC;
			pos_q        <= 3'd0;
			name_left_q  <= 8'd0;
			acc_q        <= 32'd0;
			mism_q       <= 1'b0;
			rec_cnt_q    <= '0;
			fill_q       <= '0;
			rd_idx_q     <= '0;
			body_left_q  <= 32'd0;
			body_start_q <= 1'b0;
			fault_q      <= FAULT_NONE;
		end else begin
			phase_q      <= phase_d;
			pos_q        <= pos_d;
			name_left_q  <= name_left_d;
			acc_q        <= acc_d;
			mism_q       <= mism_d;
			rec_cnt_q    <= rec_cnt_d;
			fill_q       <= fill_d;
			rd_idx_q     <= rd_idx_d;
			body_left_q  <= body_left_d;
			body_start_q <= body_start_d;
			fault_q      <= fault_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/xor_archive_stream_deframer.sv =====
// Top level: input register, parser, result register and config port.
//
//  channel  | dir | beat                         | payload
//  s_axis   | in  | s_tvalid & s_tready          | tdata = raw_byte
//  m_axis   | out | m_tvalid & m_tready          | tdata/tuser/tlast = tagged byte
//  apb      | in  | psel & penable & pwrite      | xor_key at address 0
//
// One byte per cycle while the output is not stalled: a beat lands in the
// input register, is parsed and then lands in the result register.
// The record table is read ahead so body bytes need no stall.
// Reset (async, active low) returns to the magic phase with key 0xF7.
// A stalled output holds its beat; the input register keeps taking beats
// as long as the result register frees up in the same cycle.
`default_nettype none

module xor_archive_stream_deframer
	import xasd_pkg::*;
#(
	parameter int MAX_RECORDS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] raw_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // [7:0] plain_byte, [15:8] record_number,
	                                    // [47:16] size_value, [56:48] records_seen,
	                                    // [58:57] fault, [63:59] zero
	output logic [3:0]       m_tuser,   // [3:0] section
	output logic             m_tlast,   // field_end
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [7:0] xor_key;
	logic       vld_s1;
	logic [7:0] raw_s1;
	logic       vld_s2;
	result_t    res_s2;
	result_t    res;
	logic       adv;

	xasd_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.xor_key(xor_key)
	);

	assign adv      = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || adv;

	xasd_parser #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (adv),
		.plain (raw_s1 ^ xor_key),
		.result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				vld_s1 <= s_tvalid;
			end
			if (adv) begin
				vld_s2 <= 1'b1;
			end else if (m_tready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			raw_s1 <= s_tdata;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tuser  = res_s2.section;
	assign m_tlast  = res_s2.field_end;
	assign m_tdata  = {5'd0, res_s2.fault, res_s2.records_seen, res_s2.size_value,
		res_s2.record_number, res_s2.plain_byte};

endmodule

`default_nettype wire

// ===== hdl/xasd_checker.sv =====
// Port-level checks on the deframer output stream, bound to the top level.
`default_nettype none

module xasd_checker
	import xasd_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata,
	input wire logic [3:0]  m_tuser,
	input wire logic        m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	a_drop_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == SEC_DROP) |-> (m_tdata[58:57] != FAULT_NONE))
		else $error("dropped byte without a fault");

	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == SEC_DROP) |-> !m_tlast && (m_tdata[47:8] == 40'd0))
		else $error("dropped byte carries field data");

	a_size_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != SEC_SIZE) |-> (m_tdata[47:16] == 32'd0))
		else $error("size value outside the size field");

endmodule

bind xor_archive_stream_deframer xasd_checker u_xasd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

`default_nettype wire
